// File: hdl/cmpl_pkg.sv
// ----------------------------------------------------------------------------
// cmpl_pkg
// Shared types and constants of the colour marker peak locator.
// ----------------------------------------------------------------------------
package cmpl_pkg;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 12;
  localparam int BEST_W    = 10;
  localparam int VAL_W     = BEST_W + 1;
  localparam int CFG_DIM_W = 13;
  localparam int SKIP_W    = 4;
  localparam int THR_W     = 10;
  localparam int CFG_W     = 13;
  localparam int IDX_W     = 2;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 104;

  localparam int DEF_MAX_DIM = 4096;

  localparam logic [CFG_DIM_W-1:0] RST_WIDTH     = 13'd640;
  localparam logic [CFG_DIM_W-1:0] RST_HEIGHT    = 13'd480;
  localparam logic [SKIP_W-1:0]    RST_SKIP      = 4'd3;
  localparam logic [THR_W-1:0]     RST_THRESHOLD = 10'd50;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_BORDER_SKIP  = 2'd2;
  localparam logic [IDX_W-1:0] REG_THRESHOLD    = 2'd3;

  typedef struct packed {
    logic [BEST_W-1:0]  best;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } peak_t;

endpackage

// File: hdl/cmpl_track.sv
// ----------------------------------------------------------------------------
// cmpl_track
// Running maximum of one score with the position where it first occurred.
// ----------------------------------------------------------------------------
module cmpl_track (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic                                clear,
  input  logic signed [cmpl_pkg::VAL_W-1:0]   value,
  input  logic [cmpl_pkg::COORD_W-1:0]        col,
  input  logic [cmpl_pkg::COORD_W-1:0]        row,
  output cmpl_pkg::peak_t                     peak_next
);

  cmpl_pkg::peak_t peak;
  cmpl_pkg::peak_t peak_upd;

  always_comb begin
    peak_upd = peak;
    // strictly greater only, so the first pixel keeps a tie
    if (step && (value > $signed({1'b0, peak.best}))) begin
      peak_upd.best = value[cmpl_pkg::BEST_W-1:0];
      peak_upd.col  = col;
      peak_upd.row  = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      peak <= '0;
    end else begin
      peak <= peak_upd;
    end
  end

  assign peak_next = peak_upd;

endmodule

// File: hdl/color_marker_peak_locator_core.sv
// ----------------------------------------------------------------------------
// color_marker_peak_locator_core
// Per-frame search for the strongest blue, green and red dominance and the
// brightest pixel of a raster-order BGR stream.
// ----------------------------------------------------------------------------
// One pixel is taken per clock. The block counts column and row itself from
// frame_width and frame_height; only the top border_skip rows and left
// border_skip columns are skipped. A pixel goes through one input register
// and one update stage; the frame result is registered when the last pixel
// of a frame leaves the input register. The input only stalls when the last
// pixel of a frame waits while the previous frame's result has not been taken.
module color_marker_peak_locator_core #(
  parameter int MAX_DIM = cmpl_pkg::DEF_MAX_DIM
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [cmpl_pkg::IDX_W-1:0]    cfg_index,
  input  logic [cmpl_pkg::CFG_W-1:0]    cfg_data,
  // pixel stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cmpl_pkg::IN_W-1:0]     s_tdata,  // blue, green, red
  // frame result
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // blue_col, blue_row, green_col, green_row, red_col, red_row,
  // white_col, white_row, markers_found, zero pad
  output logic [cmpl_pkg::OUT_W-1:0]    m_tdata
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int EW = (CW + 1 > cmpl_pkg::CFG_DIM_W) ? CW + 1 : cmpl_pkg::CFG_DIM_W;
  localparam int PW = cmpl_pkg::PIX_W;
  localparam int VW = cmpl_pkg::VAL_W;

  // configuration registers
  logic [cmpl_pkg::CFG_DIM_W-1:0] frame_width;
  logic [cmpl_pkg::CFG_DIM_W-1:0] frame_height;
  logic [cmpl_pkg::SKIP_W-1:0]    border_skip;
  logic [cmpl_pkg::THR_W-1:0]     detect_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= cmpl_pkg::RST_WIDTH;
      frame_height     <= cmpl_pkg::RST_HEIGHT;
      border_skip      <= cmpl_pkg::RST_SKIP;
      detect_threshold <= cmpl_pkg::RST_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cmpl_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        cmpl_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        cmpl_pkg::REG_BORDER_SKIP:
          border_skip <= cfg_data[cmpl_pkg::SKIP_W-1:0];
        cmpl_pkg::REG_THRESHOLD:
          detect_threshold <= cfg_data[cmpl_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [EW-1:0] w_eff;
  logic [EW-1:0] h_eff;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = EW'(1);
    end else if (EW'(frame_width) > EW'(MAX_DIM)) begin
      w_eff = EW'(MAX_DIM);
    end else begin
      w_eff = EW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = EW'(1);
    end else if (EW'(frame_height) > EW'(MAX_DIM)) begin
      h_eff = EW'(MAX_DIM);
    end else begin
      h_eff = EW'(frame_height);
    end
  end

  // raster position
  logic [CW-1:0] col_cnt;
  logic [CW-1:0] row_cnt;
  logic          col_end;
  logic          row_end;
  logic          in_win;
  logic          accept;

  assign col_end = (EW'(col_cnt) + EW'(1)) >= w_eff;
  assign row_end = (EW'(row_cnt) + EW'(1)) >= h_eff;
  assign in_win  = (EW'(row_cnt) >= EW'(border_skip)) &&
                   (EW'(col_cnt) >= EW'(border_skip));
  assign accept  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_cnt <= '0;
        row_cnt <= row_end ? '0 : row_cnt + CW'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // input register
  logic                          s1_valid;
  logic [PW-1:0]                 s1_blue;
  logic [PW-1:0]                 s1_green;
  logic [PW-1:0]                 s1_red;
  logic [cmpl_pkg::COORD_W-1:0]  s1_col;
  logic [cmpl_pkg::COORD_W-1:0]  s1_row;
  logic                          s1_win;
  logic                          s1_last;
  logic                          consume;

  assign consume  = s1_valid && (!s1_last || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_blue  <= s_tdata[PW-1:0];
      s1_green <= s_tdata[2*PW-1:PW];
      s1_red   <= s_tdata[3*PW-1:2*PW];
      s1_col   <= cmpl_pkg::COORD_W'(col_cnt);
      s1_row   <= cmpl_pkg::COORD_W'(row_cnt);
      s1_win   <= in_win;
      s1_last  <= col_end && row_end;
    end
  end

  // scores
  logic signed [VW-1:0] b_s;
  logic signed [VW-1:0] g_s;
  logic signed [VW-1:0] r_s;
  logic signed [VW-1:0] blue_dom;
  logic signed [VW-1:0] green_dom;
  logic signed [VW-1:0] red_dom;
  logic signed [VW-1:0] white_sum;

  assign b_s       = $signed({{(VW-PW){1'b0}}, s1_blue});
  assign g_s       = $signed({{(VW-PW){1'b0}}, s1_green});
  assign r_s       = $signed({{(VW-PW){1'b0}}, s1_red});
  assign blue_dom  = b_s - (r_s + g_s);
  assign green_dom = g_s - (r_s + b_s);
  assign red_dom   = r_s - (g_s + b_s);
  assign white_sum = r_s + g_s + b_s;

  logic            trk_step;
  logic            trk_clear;
  cmpl_pkg::peak_t pk_blue;
  cmpl_pkg::peak_t pk_green;
  cmpl_pkg::peak_t pk_red;
  cmpl_pkg::peak_t pk_white;

  assign trk_step  = consume && s1_win;
  assign trk_clear = consume && s1_last;

  cmpl_track u_blue (
    .clk(clk), .rst(rst), .step(trk_step), .clear(trk_clear),
    .value(blue_dom), .col(s1_col), .row(s1_row), .peak_next(pk_blue)
  );

  cmpl_track u_green (
    .clk(clk), .rst(rst), .step(trk_step), .clear(trk_clear),
    .value(green_dom), .col(s1_col), .row(s1_row), .peak_next(pk_green)
  );

  cmpl_track u_red (
    .clk(clk), .rst(rst), .step(trk_step), .clear(trk_clear),
    .value(red_dom), .col(s1_col), .row(s1_row), .peak_next(pk_red)
  );

  cmpl_track u_white (
    .clk(clk), .rst(rst), .step(trk_step), .clear(trk_clear),
    .value(white_sum), .col(s1_col), .row(s1_row), .peak_next(pk_white)
  );

  // result register
  logic found;

  assign found = (pk_blue.best  > detect_threshold) &&
                 (pk_green.best > detect_threshold) &&
                 (pk_red.best   > detect_threshold) &&
                 (pk_white.best > detect_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (trk_clear) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (trk_clear) begin
      m_tdata <= {7'b0, found,
                  pk_white.row, pk_white.col,
                  pk_red.row,   pk_red.col,
                  pk_green.row, pk_green.col,
                  pk_blue.row,  pk_blue.col};
    end
  end

`ifndef SYNTH
  // a result only appears after the last pixel of a frame left the input stage
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(consume && s1_last))
    else $error("result raised without a completed frame");

  // a held pixel keeps its data until the update stage takes it
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !consume |=> s1_valid && $stable(s1_col) && $stable(s1_row) &&
    $stable(s1_last))
    else $error("input stage lost a waiting pixel");

  // the input only stalls behind a frame end that waits for the result slot
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> s1_valid && s1_last && m_tvalid && !m_tready)
    else $error("input stalled without a waiting frame result");
`endif

endmodule
